>>> sv/assert_macros.svh
// Assertion macros shared by the integrator RTL.
// Relies on clk and rst being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sia_pkg.sv
// Shared types, constants and helpers for the sampled integral accumulator.
// No dependencies; imported by sia_lane and the top level.
`default_nettype none

package sia_pkg;

  localparam int MAX_LANES = 4;
  localparam int LANES     = 4;

  localparam int VAL_W = 32;
  localparam int DT_W  = VAL_W + 1;
  localparam int SUM_W = 64;

  localparam logic [1:0] RULE_TRAP = 2'd0;
  localparam logic [1:0] RULE_FWD  = 2'd1;
  localparam logic [1:0] RULE_BWD  = 2'd2;
  localparam logic [1:0] RULE_OFF  = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] time_stamp;
    logic signed [VAL_W-1:0] sample_0;
    logic signed [VAL_W-1:0] sample_1;
    logic signed [VAL_W-1:0] sample_2;
    logic signed [VAL_W-1:0] sample_3;
    logic                    last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] integral_0;
    logic signed [SUM_W-1:0] integral_1;
    logic signed [SUM_W-1:0] integral_2;
    logic signed [SUM_W-1:0] integral_3;
  } result_t;

  // Per-cycle control broadcast from the top level to every lane.
  typedef struct packed {
    logic       load;   // sample transfer this cycle
    logic       step;   // pipeline advances
    logic       acc;    // stage B item commits to the accumulator
    logic       add;    // committing item carries an interval
    logic       clear;  // committing item ends the series
    logic [1:0] mode;
  } lane_ctrl_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] r;
    s = a + b;
    r = s;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
      r = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/sia_lane.sv
// One integration lane: value pick, dt * value product, saturating accumulator.
// Depends on sia_pkg for widths, rule codes, control struct and sat_add.
`default_nettype none

module sia_lane (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sia_pkg::lane_ctrl_t             ctrl,
  input  wire logic signed [sia_pkg::VAL_W-1:0] cur,
  input  wire logic signed [sia_pkg::DT_W-1:0]  dt,
  output logic signed [sia_pkg::SUM_W-1:0]      sum_out
);
  import sia_pkg::*;

  logic signed [VAL_W-1:0]   prior_val;
  logic signed [VAL_W-1:0]   pick;
  logic signed [VAL_W-1:0]   pick_next;
  logic signed [VAL_W:0]     pair;
  logic signed [SUM_W:0]     prod_full;
  logic signed [SUM_W-1:0]   prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_next;

  // floor((left + right) / 2) is the 33-bit sum shifted right by one
  assign pair = {prior_val[VAL_W-1], prior_val} + {cur[VAL_W-1], cur};

  always_comb begin
    case (ctrl.mode)
      RULE_TRAP: pick_next = pair[VAL_W:1];
      RULE_FWD:  pick_next = prior_val;
      RULE_BWD:  pick_next = cur;
      default:   pick_next = cur;
    endcase
  end

  assign prod_full = dt * pick;

  always_comb begin
    sum_next = sum;
    if (ctrl.add) begin
      sum_next = sat_add(sum, prod);
    end
  end

  assign sum_out = sum_next;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prior_val <= cur;
    end
    if (ctrl.step) begin
      pick <= pick_next;
      prod <= prod_full[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= ctrl.clear ? '0 : sum_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/sampled_integral_accumulator.sv
// A last sample passes the stage A and stage B registers before its commit loads the result register.
// Throughput: one sample per cycle; lanes run side by side, each with one
// 33x32 multiplier and a 64-bit saturating adder closing the accumulate loop.
// A second series end stalls input only while the previous result is unread.
// Reset (rst, synchronous): rule_mode = trapezoid, no prior sample, sums zero.
`default_nettype none

`include "assert_macros.svh"

module sampled_integral_accumulator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  sample_stall,
  input  wire sia_pkg::sample_t sample_data,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output sia_pkg::result_t      result_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_data
);
  import sia_pkg::*;

  logic [1:0]              rule_mode;
  logic                    have_prior;
  logic signed [VAL_W-1:0] prior_time;

  logic                    a_valid;
  logic                    a_last;
  logic                    a_active;
  logic signed [DT_W-1:0]  dt;
  logic signed [DT_W-1:0]  dt_next;

  logic                    b_valid;
  logic                    b_last;
  logic                    b_active;

  logic                    en;
  logic                    sample_fire;
  logic                    commit;
  lane_ctrl_t              ctrl;

  logic signed [VAL_W-1:0] cur  [MAX_LANES];
  logic signed [SUM_W-1:0] sums [MAX_LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode <= RULE_TRAP;
    end else if (cfg_valid && cfg_ready) begin
      rule_mode <= cfg_data;
    end
  end

  // Pipeline holds only when a series end must load a full result register.
  assign en           = !(b_valid && b_last && result_valid && result_stall);
  assign sample_stall = !en;
  assign sample_fire  = sample_valid && en;
  assign commit       = en && b_valid;

  assign dt_next = {sample_data.time_stamp[VAL_W-1], sample_data.time_stamp}
                 - {prior_time[VAL_W-1], prior_time};

  always_comb begin
    ctrl.load  = sample_fire;
    ctrl.step  = en;
    ctrl.acc   = commit;
    ctrl.add   = commit && b_active;
    ctrl.clear = b_last;
    ctrl.mode  = rule_mode;
  end

  assign cur[0] = sample_data.sample_0;
  assign cur[1] = sample_data.sample_1;
  assign cur[2] = sample_data.sample_2;
  assign cur[3] = sample_data.sample_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prior <= 1'b0;
    end else if (sample_fire) begin
      have_prior <= !sample_data.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      prior_time <= sample_data.time_stamp;
    end
    if (en) begin
      dt <= dt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      a_last   <= 1'b0;
      a_active <= 1'b0;
      b_valid  <= 1'b0;
      b_last   <= 1'b0;
      b_active <= 1'b0;
    end else if (en) begin
      a_valid  <= sample_fire;
      a_last   <= sample_fire && sample_data.last_sample;
      a_active <= sample_fire && have_prior && (rule_mode != RULE_OFF);
      b_valid  <= a_valid;
      b_last   <= a_last;
      b_active <= a_active;
    end
  end

  for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
    if (k < LANES) begin : g_on
      sia_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .cur     (cur[k]),
        .dt      (dt),
        .sum_out (sums[k])
      );
    end else begin : g_off
      assign sums[k] = '0;
    end
  end

  // Merge: latch all lane sums into the result register at series end.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit && b_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && b_last) begin
      result_data.integral_0 <= sums[0];
      result_data.integral_1 <= sums[1];
      result_data.integral_2 <= sums[2];
      result_data.integral_3 <= sums[3];
    end
  end

  `ASSERT_IMPLIES(a_stall_cause, sample_stall, b_valid && b_last && result_valid,
                  "input stalled without a blocked series end")
  `ASSERT_IMPLIES(a_active_valid, a_active || a_last, a_valid,
                  "stage A flags set on a bubble")
  `ASSERT_NEXT(a_series_end, commit && b_last, result_valid,
               "series end did not load the result register")
  `ASSERT_NEXT(a_restart, sample_fire && sample_data.last_sample, !have_prior,
               "prior sample kept across series end")

endmodule

`default_nettype wire
